FILE: hw/rtl/crpi_pkg.sv
// Shared types, widths and the weight function of the Catmull-Rom point interpolator.
package crpi_pkg;

    // Field widths.
    localparam int COORD_W  = 16;
    localparam int OUT_W    = 18;
    localparam int U_W      = 4;
    localparam int WEIGHT_W = 16;
    localparam int PROD_W   = 32;
    localparam int SUM_W    = 32;
    localparam int MAG_W    = 31;
    localparam int Q_W      = 17;
    localparam int RECIP_SHIFT = 31;

    // Output range.
    localparam logic signed [OUT_W:0] OUT_MAX = (OUT_W+1)'(131071);
    localparam logic signed [OUT_W:0] OUT_MIN = -(OUT_W+1)'(131072);

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_point;

    // One sample request: four control points, the step along the span and the end mark.
    typedef struct packed {
        t_point [3:0]   pt;
        logic [U_W-1:0] u;
        logic           run_end;
    } t_req;

    // Weighted sums of one sample, x in entry 0 and y in entry 1.
    typedef struct packed {
        logic [1:0][SUM_W-1:0] sum;
        logic                  run_end;
    } t_sum;

    // Basis weight k of a uniform Catmull-Rom span at step u of n, scaled by 2*n^3.
    function automatic logic signed [WEIGHT_W-1:0] cr_weight(input logic [1:0] k,
                                                              input logic [U_W-1:0] u,
                                                              input int n);
        int uu;
        int u2;
        int u3;
        int n2;
        int w;
        uu = int'(u);
        u2 = uu * uu;
        u3 = u2 * uu;
        n2 = n * n;
        unique case (k)
            2'd0:    w = -u3 + 2 * u2 * n - uu * n2;
            2'd1:    w = 3 * u3 - 5 * u2 * n + 2 * n2 * n;
            2'd2:    w = -3 * u3 + 4 * u2 * n + uu * n2;
            default: w = u3 - u2 * n;
        endcase
        return WEIGHT_W'(w);
    endfunction

endpackage

FILE: hw/rtl/catmull_rom_point_interpolator.sv
// Top level of the streaming uniform Catmull-Rom point interpolator.
//
// Points of a polyline enter on the input channel (i_valid / o_ready) with
// i_end_of_line set on the last point. Samples leave on the output channel
// (o_valid / i_ready), SEGMENTS per span, with o_run_end set on the final
// request of a polyline, which is the last point passed through unchanged.
// A point completes the span two points back; the last point also produces
// the final span and then itself. A lone point passes straight through.
// The first sample of a point passes the request, product, sum, r3, r4, r5
// and output registers after the point is accepted. Throughput: one sample
// per cycle while the receiver does not stall, set by the span sequencer
// issuing one sample request per cycle. A point is taken as the last request of
// the one before issues; steady-state points cause SEGMENTS, the last 2*SEGMENTS+1.
// Reset clears the point window and all pipeline valid bits, starting a new
// polyline. When the receiver stalls, the whole sample pipeline holds and
// o_ready drops once the sequencer has no room for another point.
module catmull_rom_point_interpolator #(
    parameter int SEGMENTS = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [crpi_pkg::COORD_W-1:0] i_px,
    input  logic signed [crpi_pkg::COORD_W-1:0] i_py,
    input  logic                              i_end_of_line,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [crpi_pkg::OUT_W-1:0] o_qx,
    output logic signed [crpi_pkg::OUT_W-1:0] o_qy,
    output logic                              o_run_end
);

    logic           en;
    logic           req_valid;
    crpi_pkg::t_req req;
    logic           sum_valid;
    crpi_pkg::t_sum sum;

    // The pipeline moves whenever the output register is empty or being taken.
    assign en = !o_valid || i_ready;

    crpi_seq #(
        .SEGMENTS(SEGMENTS)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_px          (i_px),
        .i_py          (i_py),
        .i_end_of_line (i_end_of_line),
        .i_en          (en),
        .o_req_valid   (req_valid),
        .o_req         (req)
    );

    crpi_blend #(
        .SEGMENTS(SEGMENTS)
    ) u_blend (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_sum_valid (sum_valid),
        .o_sum       (sum)
    );

    crpi_scale #(
        .SEGMENTS(SEGMENTS)
    ) u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_sum_valid (sum_valid),
        .i_sum       (sum),
        .o_valid     (o_valid),
        .o_qx        (o_qx),
        .o_qy        (o_qy),
        .o_run_end   (o_run_end)
    );

endmodule

FILE: hw/rtl/crpi_seq.sv
// Point window and span sequencer: turns each input point into sample requests.
module crpi_seq #(
    parameter int SEGMENTS = 5
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [crpi_pkg::COORD_W-1:0] i_px,
    input  logic signed [crpi_pkg::COORD_W-1:0] i_py,
    input  logic                            i_end_of_line,
    input  logic                            i_en,
    output logic                            o_req_valid,
    output crpi_pkg::t_req                  o_req
);

    localparam logic [crpi_pkg::U_W-1:0] U_LAST = crpi_pkg::U_W'(SEGMENTS - 1);

    typedef enum logic [1:0] {
        PH_A,
        PH_B,
        PH_P
    } t_phase;

    crpi_pkg::t_point r_win [3];
    logic [1:0]       r_seen;
    logic             r_busy;
    t_phase           r_phase;
    logic [crpi_pkg::U_W-1:0] r_u;
    logic             r_last;
    crpi_pkg::t_point r_e0;
    crpi_pkg::t_point r_e1;
    crpi_pkg::t_point r_e2;
    crpi_pkg::t_point r_e3;
    crpi_pkg::t_point r_eb;

    crpi_pkg::t_point in_pt;
    logic             step_done;
    logic             finish;
    logic             accept;
    logic             has_a;
    logic             has_b;

    assign in_pt.x = i_px;
    assign in_pt.y = i_py;

    // The pass-through step is a single sample; span steps run over all segments.
    assign step_done = (r_phase == PH_P) || (r_u == U_LAST);
    assign finish    = r_busy && i_en && step_done &&
                       ((r_phase == PH_P) || ((r_phase == PH_A) && !r_last));
    assign o_ready   = !r_busy || finish;
    assign accept    = i_valid && o_ready;
    assign has_a     = r_seen[1];
    assign has_b     = (r_seen != 2'd0);

    // Select the control points of the current step.
    always_comb begin
        o_req_valid = r_busy;
        o_req.u       = r_u;
        o_req.run_end = 1'b0;
        unique case (r_phase)
            PH_A: begin
                o_req.pt[0] = r_e0;
                o_req.pt[1] = r_e1;
                o_req.pt[2] = r_e2;
                o_req.pt[3] = r_e3;
            end
            PH_B: begin
                o_req.pt[0] = r_eb;
                o_req.pt[1] = r_e2;
                o_req.pt[2] = r_e3;
                o_req.pt[3] = r_e3;
            end
            default: begin
                o_req.pt[0]   = r_e3;
                o_req.pt[1]   = r_e3;
                o_req.pt[2]   = r_e3;
                o_req.pt[3]   = r_e3;
                o_req.u       = '0;
                o_req.run_end = 1'b1;
            end
        endcase
    end

    // Window, point count and step sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_seen  <= 2'd0;
            r_phase <= PH_A;
            r_u     <= '0;
            r_last  <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_win[i] <= '0;
            end
        end else if (accept) begin
            // Capture every point the request's steps will need.
            r_e0    <= (r_seen == 2'd2) ? r_win[1] : r_win[2];
            r_e1    <= r_win[1];
            r_e2    <= r_win[0];
            r_e3    <= in_pt;
            r_eb    <= has_a ? r_win[1] : r_win[0];
            r_last  <= i_end_of_line;
            r_busy  <= has_a || i_end_of_line;
            r_phase <= has_a ? PH_A : (has_b ? PH_B : PH_P);
            r_u     <= '0;
            if (i_end_of_line) begin
                r_seen <= 2'd0;
                for (int i = 0; i < 3; i++) begin
                    r_win[i] <= '0;
                end
            end else begin
                r_win[2] <= r_win[1];
                r_win[1] <= r_win[0];
                r_win[0] <= in_pt;
                if (r_seen != 2'd3) begin
                    r_seen <= r_seen + 2'd1;
                end
            end
        end else if (r_busy && i_en) begin
            if (step_done) begin
                r_u <= '0;
                unique case (r_phase)
                    PH_A: begin
                        if (r_last) begin
                            r_phase <= PH_B;
                        end else begin
                            r_busy <= 1'b0;
                        end
                    end
                    PH_B: begin
                        r_phase <= PH_P;
                    end
                    default: begin
                        r_busy <= 1'b0;
                    end
                endcase
            end else begin
                r_u <= r_u + 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/crpi_blend.sv
// Weight lookup, products and weighted sums of one sample, two pipeline stages.
module crpi_blend #(
    parameter int SEGMENTS = 5
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_req_valid,
    input  crpi_pkg::t_req i_req,
    output logic           o_sum_valid,
    output crpi_pkg::t_sum o_sum
);

    localparam int PW = crpi_pkg::PROD_W;
    localparam int SW = crpi_pkg::SUM_W;

    logic signed [crpi_pkg::WEIGHT_W-1:0] w [4];
    crpi_pkg::t_coord                     coord [2][4];
    logic signed [PW-1:0]                 r_prod [2][4];
    logic                                 r_prod_valid;
    logic                                 r_prod_end;
    logic signed [SW+1:0]                 acc [2];

    // Weights of this step and the coordinates they apply to.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w[k]        = crpi_pkg::cr_weight(2'(k), i_req.u, SEGMENTS);
            coord[0][k] = i_req.pt[k].x;
            coord[1][k] = i_req.pt[k].y;
        end
    end

    // Sum of the four products; the true value stays well inside SUM_W bits.
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            acc[c] = (SW+2)'(r_prod[c][0]) + (SW+2)'(r_prod[c][1])
                   + (SW+2)'(r_prod[c][2]) + (SW+2)'(r_prod[c][3]);
        end
    end

    // Product stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else if (i_en) begin
            r_prod_valid <= i_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_end <= i_req.run_end;
            for (int c = 0; c < 2; c++) begin
                for (int k = 0; k < 4; k++) begin
                    r_prod[c][k] <= PW'(coord[c][k]) * PW'(w[k]);
                end
            end
        end
    end

    // Sum stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_sum_valid <= 1'b0;
        end else if (i_en) begin
            o_sum_valid <= r_prod_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sum.run_end <= r_prod_end;
            for (int c = 0; c < 2; c++) begin
                o_sum.sum[c] <= acc[c][SW-1:0];
            end
        end
    end

endmodule

FILE: hw/rtl/crpi_scale.sv
// Division by the weight scale with truncation toward zero, saturation and output register.
module crpi_scale #(
    parameter int SEGMENTS = 5
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_sum_valid,
    input  crpi_pkg::t_sum                      i_sum,
    output logic                                o_valid,
    output logic signed [crpi_pkg::OUT_W-1:0]   o_qx,
    output logic signed [crpi_pkg::OUT_W-1:0]   o_qy,
    output logic                                o_run_end
);

    localparam int MW = crpi_pkg::MAG_W;
    localparam int QW = crpi_pkg::Q_W;
    localparam int OW = crpi_pkg::OUT_W;
    localparam int DIVISOR_INT = 2 * SEGMENTS * SEGMENTS * SEGMENTS;
    localparam logic [MW:0] DIVISOR = (MW+1)'(DIVISOR_INT);
    // Reciprocal rounded down; the estimate is the quotient or one below it.
    localparam logic [31:0] RECIP =
        32'((64'd1 << crpi_pkg::RECIP_SHIFT) / DIVISOR_INT);

    logic            r3_valid;
    logic            r3_end;
    logic [1:0]      r3_neg;
    logic [MW-1:0]   r3_mag [2];
    logic            r4_valid;
    logic            r4_end;
    logic [1:0]      r4_neg;
    logic [MW-1:0]   r4_mag [2];
    logic [QW-1:0]   r4_q [2];
    logic            r5_valid;
    logic            r5_end;
    logic [1:0]      r5_neg;
    logic [QW-1:0]   r5_q [2];

    logic signed [crpi_pkg::SUM_W-1:0] sum_s [2];
    logic [MW+31:0]  recip_prod [2];
    logic [MW:0]     rem [2];
    logic signed [OW:0] res [2];
    logic signed [OW:0] sat [2];

    // Quotient estimate, remainder check, signed result and saturation.
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            sum_s[c]      = $signed(i_sum.sum[c]);
            recip_prod[c] = (MW+32)'(r3_mag[c]) * (MW+32)'(RECIP);
            rem[c]        = (MW+1)'(r4_mag[c]) - ((MW+1)'(r4_q[c]) * DIVISOR);
            res[c]        = r5_neg[c] ? -(OW+1)'(r5_q[c]) : (OW+1)'(r5_q[c]);
            if (res[c] > crpi_pkg::OUT_MAX) begin
                sat[c] = crpi_pkg::OUT_MAX;
            end else if (res[c] < crpi_pkg::OUT_MIN) begin
                sat[c] = crpi_pkg::OUT_MIN;
            end else begin
                sat[c] = res[c];
            end
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            o_valid  <= 1'b0;
        end else if (i_en) begin
            r3_valid <= i_sum_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            o_valid  <= r5_valid;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_end    <= i_sum.run_end;
            r4_end    <= r3_end;
            r5_end    <= r4_end;
            o_run_end <= r5_end;
            r4_neg    <= r3_neg;
            r5_neg    <= r4_neg;
            for (int c = 0; c < 2; c++) begin
                r3_neg[c] <= sum_s[c][crpi_pkg::SUM_W-1];
                r3_mag[c] <= sum_s[c][crpi_pkg::SUM_W-1] ? MW'(-sum_s[c]) : MW'(sum_s[c]);
                r4_mag[c] <= r3_mag[c];
                r4_q[c]   <= recip_prod[c][crpi_pkg::RECIP_SHIFT +: QW];
                r5_q[c]   <= (rem[c] >= DIVISOR) ? r4_q[c] + 1'b1 : r4_q[c];
            end
            o_qx <= sat[0][OW-1:0];
            o_qy <= sat[1][OW-1:0];
        end
    end

endmodule

FILE: bench/crpi_sample_checker.sv
// Checker for the Catmull-Rom point interpolator: predicts and compares the samples.
`timescale 1ns / 100ps

module crpi_sample_checker #(
    parameter int SEGMENTS = 5
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic signed [crpi_pkg::COORD_W-1:0] i_px,
    input  logic signed [crpi_pkg::COORD_W-1:0] i_py,
    input  logic                                i_end_of_line,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [crpi_pkg::OUT_W-1:0]   i_qx,
    input  logic signed [crpi_pkg::OUT_W-1:0]   i_qy,
    input  logic                                i_run_end,
    output int                                  o_mismatches,
    output int                                  o_pending,
    output int                                  o_checked
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [crpi_pkg::OUT_W-1:0] qx;
        logic signed [crpi_pkg::OUT_W-1:0] qy;
        logic                              run_end;
    } t_sample;

    // Samples owed by the block, oldest first.
    t_sample due_samples[$];

    // Point history of the current polyline, newest in entry 0.
    crpi_pkg::t_coord hist_x[3];
    crpi_pkg::t_coord hist_y[3];
    logic [1:0]       pts_held;

    int err_count;
    int seen_count;

    // Clamps an exact coordinate into the 18-bit output range.
    function automatic logic signed [crpi_pkg::OUT_W-1:0] clamp_out(input longint v);
        if (v > longint'(crpi_pkg::OUT_MAX)) begin
            return crpi_pkg::OUT_MAX[crpi_pkg::OUT_W-1:0];
        end
        if (v < longint'(crpi_pkg::OUT_MIN)) begin
            return crpi_pkg::OUT_MIN[crpi_pkg::OUT_W-1:0];
        end
        return v[crpi_pkg::OUT_W-1:0];
    endfunction

    // One coordinate of a uniform Catmull-Rom sample at step/SEGMENTS,
    // exact weighted sum divided by 2*N^3 with truncation toward zero.
    function automatic logic signed [crpi_pkg::OUT_W-1:0] spline_blend(
        input longint c0, input longint c1,
        input longint c2, input longint c3,
        input int step);
        longint u;
        longint n;
        longint w0;
        longint w1;
        longint w2;
        longint w3;
        longint acc;
        u   = step;
        n   = SEGMENTS;
        w0  = -u * u * u + 2 * u * u * n - u * n * n;
        w1  = 3 * u * u * u - 5 * u * u * n + 2 * n * n * n;
        w2  = -3 * u * u * u + 4 * u * u * n + u * n * n;
        w3  = u * u * u - u * u * n;
        acc = c0 * w0 + c1 * w1 + c2 * w2 + c3 * w3;
        return clamp_out(acc / (2 * n * n * n));
    endfunction

    // Appends one sample to the owed list.
    task automatic owe_sample(input t_sample smp);
        due_samples.insert(due_samples.size(), smp);
    endtask

    // Queues all samples of one span from its four control points.
    task automatic queue_span_samples(input longint ax, input longint ay,
                                      input longint bx, input longint by,
                                      input longint cx, input longint cy,
                                      input longint dx, input longint dy);
        t_sample smp;
        for (int s = 0; s < SEGMENTS; s++) begin
            smp.qx      = spline_blend(ax, bx, cx, dx, s);
            smp.qy      = spline_blend(ay, by, cy, dy, s);
            smp.run_end = 1'b0;
            owe_sample(smp);
        end
    endtask

    task automatic clear_history();
        for (int i = 0; i < 3; i++) begin
            hist_x[i] = '0;
            hist_y[i] = '0;
        end
        pts_held = 2'd0;
    endtask

    // Advances the polyline by one point and queues the samples it completes.
    task automatic advance_polyline(input crpi_pkg::t_coord x, input crpi_pkg::t_coord y,
                                    input logic last);
        t_sample          smp;
        crpi_pkg::t_coord lead_x;
        crpi_pkg::t_coord lead_y;
        // The span two points back, with the first point repeated at the start.
        if (pts_held == 2'd2) begin
            queue_span_samples(hist_x[1], hist_y[1], hist_x[1], hist_y[1],
                               hist_x[0], hist_y[0], x, y);
        end else if (pts_held == 2'd3) begin
            queue_span_samples(hist_x[2], hist_y[2], hist_x[1], hist_y[1],
                               hist_x[0], hist_y[0], x, y);
        end
        if (last) begin
            // Final span with the last point repeated, then the point itself.
            if (pts_held >= 2'd1) begin
                lead_x = (pts_held >= 2'd2) ? hist_x[1] : hist_x[0];
                lead_y = (pts_held >= 2'd2) ? hist_y[1] : hist_y[0];
                queue_span_samples(lead_x, lead_y, hist_x[0], hist_y[0], x, y, x, y);
            end
            smp.qx      = clamp_out(longint'(x));
            smp.qy      = clamp_out(longint'(y));
            smp.run_end = 1'b1;
            owe_sample(smp);
            clear_history();
        end else begin
            hist_x[2] = hist_x[1];
            hist_y[2] = hist_y[1];
            hist_x[1] = hist_x[0];
            hist_y[1] = hist_y[0];
            hist_x[0] = x;
            hist_y[0] = y;
            if (pts_held != 2'd3) begin
                pts_held = pts_held + 2'd1;
            end
        end
    endtask

    // Compares one sample leaving the block with the oldest one owed.
    task automatic check_sample(input logic signed [crpi_pkg::OUT_W-1:0] got_x,
                                input logic signed [crpi_pkg::OUT_W-1:0] got_y,
                                input logic got_end);
        t_sample want;
        if (due_samples.size() == 0) begin
            err_count++;
            if (err_count <= REPORT_LIMIT) begin
                $display("%0t: unexpected sample x=%0d y=%0d run_end=%0b",
                         $realtime, got_x, got_y, got_end);
            end
        end else begin
            want = due_samples.pop_front();
            seen_count++;
            if (want.qx !== got_x || want.qy !== got_y || want.run_end !== got_end) begin
                err_count++;
                if (err_count <= REPORT_LIMIT) begin
                    $display({"%0t: sample mismatch: expected x=%0d y=%0d run_end=%0b,",
                              " got x=%0d y=%0d run_end=%0b"},
                             $realtime, want.qx, want.qy, want.run_end,
                             got_x, got_y, got_end);
                end
            end
        end
    endtask

    // Both channels are sampled at the rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_history();
            due_samples.delete();
            err_count  = 0;
            seen_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_sample(i_qx, i_qy, i_run_end);
            end
            if (i_in_valid && i_in_ready) begin
                advance_polyline(i_px, i_py, i_end_of_line);
            end
        end
        o_mismatches <= err_count;
        o_pending    <= due_samples.size();
        o_checked    <= seen_count;
    end

endmodule

FILE: bench/tb_catmull_rom_point_interpolator.sv
// Testbench top for the Catmull-Rom point interpolator: clock, reset, point stimulus and verdict.
`timescale 1ns / 100ps

module tb_catmull_rom_point_interpolator;

    localparam int SEGMENTS       = 5;
    localparam int ITEM_TARGET    = 210;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 150;
    localparam int HOLD_AFTER     = 400;
    localparam int DRAIN_CYCLES   = 20;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_valid;
    logic                                o_ready;
    logic signed [crpi_pkg::COORD_W-1:0] i_px;
    logic signed [crpi_pkg::COORD_W-1:0] i_py;
    logic                                i_end_of_line;
    logic                                o_valid;
    logic                                i_ready;
    logic signed [crpi_pkg::OUT_W-1:0]   o_qx;
    logic signed [crpi_pkg::OUT_W-1:0]   o_qy;
    logic                                o_run_end;

    int mismatches;
    int pending;
    int checked;

    int points_sent;
    int polylines;
    int lone_points;
    int line_len_now;
    int idle_cycles;

    catmull_rom_point_interpolator #(
        .SEGMENTS(SEGMENTS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_px         (i_px),
        .i_py         (i_py),
        .i_end_of_line(i_end_of_line),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_qx         (o_qx),
        .o_qy         (o_qy),
        .o_run_end    (o_run_end)
    );

    crpi_sample_checker #(
        .SEGMENTS(SEGMENTS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_px         (i_px),
        .i_py         (i_py),
        .i_end_of_line(i_end_of_line),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_qx         (o_qx),
        .i_qy         (o_qy),
        .i_run_end    (o_run_end),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Coordinate mix: full range, values near zero and the extremes.
    function automatic crpi_pkg::t_coord rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            return crpi_pkg::t_coord'($urandom);
        end else if (r < 8) begin
            return crpi_pkg::t_coord'($urandom_range(0, 200) - 100);
        end
        case ($urandom_range(0, 3))
            0:       return crpi_pkg::t_coord'(16'h7FFF);
            1:       return crpi_pkg::t_coord'(16'h8000);
            2:       return crpi_pkg::t_coord'(16'h0000);
            default: return crpi_pkg::t_coord'(16'hFFFF);
        endcase
    endfunction

    // Offers one point, holds it until the block takes it, then may idle a while
    // unless the polyline is sent back to back. Called at a falling edge.
    task automatic put_point(input crpi_pkg::t_coord x, input crpi_pkg::t_coord y,
                             input logic last, input bit back_to_back);
        int gap;
        i_px          <= x;
        i_py          <= y;
        i_end_of_line <= last;
        i_valid       <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        @(negedge i_clk);
        points_sent++;
        if (last) begin
            polylines++;
            if (line_len_now == 0) begin
                lone_points++;
            end
            line_len_now = 0;
        end else begin
            line_len_now++;
        end
        gap = back_to_back ? 0 : rand_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Receiver: random ready pattern, with one long hold-off partway through
    // so that the sample pipeline fills and the input request stalls.
    initial begin : receiver
        int  run_len;
        int  stall_len;
        int  rx_cycles;
        bit  held_long;
        i_ready   = 1'b0;
        rx_cycles = 0;
        held_long = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (!held_long && rx_cycles >= HOLD_AFTER) begin
                i_ready   <= 1'b0;
                stall_len = LONG_HOLD;
                held_long = 1'b1;
            end else begin
                run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 8);
                i_ready <= 1'b1;
                repeat (run_len) @(negedge i_clk);
                rx_cycles += run_len;
                stall_len = rand_gap();
                if (stall_len > 0) begin
                    i_ready <= 1'b0;
                end
            end
            repeat (stall_len) @(negedge i_clk);
            rx_cycles += stall_len;
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    initial begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // Stimulus and verdict.
    initial begin : stimulus
        int len;
        int r;
        bit quiet;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_px          = '0;
        i_py          = '0;
        i_end_of_line = 1'b0;
        points_sent   = 0;
        polylines     = 0;
        lone_points   = 0;
        line_len_now  = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Lone points at opposite extremes pass straight through.
        put_point(crpi_pkg::t_coord'(16'h7FFF), crpi_pkg::t_coord'(16'h8000), 1'b1, 1'b0);
        put_point(crpi_pkg::t_coord'(16'h8000), crpi_pkg::t_coord'(16'h7FFF), 1'b1, 1'b0);

        // Two-point polylines: one span clamped at both ends.
        put_point(crpi_pkg::t_coord'(16'hFFFF), crpi_pkg::t_coord'(16'h0000), 1'b0, 1'b0);
        put_point(crpi_pkg::t_coord'(16'h0000), crpi_pkg::t_coord'(16'hFFFF), 1'b1, 1'b0);
        put_point(crpi_pkg::t_coord'(16'h7FFF), crpi_pkg::t_coord'(16'h7FFF), 1'b0, 1'b1);
        put_point(crpi_pkg::t_coord'(16'h8000), crpi_pkg::t_coord'(16'h8000), 1'b1, 1'b1);

        // Three points: the last point completes the first span.
        put_point(crpi_pkg::t_coord'(16'h8000), crpi_pkg::t_coord'(16'h7FFF), 1'b0, 1'b0);
        put_point(crpi_pkg::t_coord'(16'h7FFF), crpi_pkg::t_coord'(16'h8000), 1'b0, 1'b0);
        put_point(crpi_pkg::t_coord'(16'h8000), crpi_pkg::t_coord'(16'h7FFF), 1'b1, 1'b0);

        // Longer polyline swinging between the extremes for the largest sums.
        put_point(crpi_pkg::t_coord'(16'h7FFF), crpi_pkg::t_coord'(16'h8000), 1'b0, 1'b0);
        put_point(crpi_pkg::t_coord'(16'h8000), crpi_pkg::t_coord'(16'h7FFF), 1'b0, 1'b0);
        put_point(crpi_pkg::t_coord'(16'h7FFF), crpi_pkg::t_coord'(16'h7FFF), 1'b0, 1'b0);
        put_point(crpi_pkg::t_coord'(16'h8000), crpi_pkg::t_coord'(16'h8000), 1'b0, 1'b0);
        put_point(crpi_pkg::t_coord'(16'h7FFF), crpi_pkg::t_coord'(16'h8000), 1'b0, 1'b0);
        put_point(crpi_pkg::t_coord'(16'h8000), crpi_pkg::t_coord'(16'h7FFF), 1'b1, 1'b0);

        // Alternating bit patterns, zero and minus one.
        put_point(crpi_pkg::t_coord'(16'h5555), crpi_pkg::t_coord'(16'hAAAA), 1'b0, 1'b0);
        put_point(crpi_pkg::t_coord'(16'hAAAA), crpi_pkg::t_coord'(16'h5555), 1'b0, 1'b0);
        put_point(crpi_pkg::t_coord'(16'h0000), crpi_pkg::t_coord'(16'h0000), 1'b0, 1'b0);
        put_point(crpi_pkg::t_coord'(16'hFFFF), crpi_pkg::t_coord'(16'hFFFF), 1'b1, 1'b0);

        // Random polylines, every one closed by its last point.
        while (points_sent < ITEM_TARGET) begin
            r     = $urandom_range(0, 9);
            len   = (r == 0) ? 1 : (r == 1) ? 2 : (r == 2) ? 3 : $urandom_range(4, 12);
            quiet = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < len; i++) begin
                put_point(rand_coord(), rand_coord(), (i == len - 1), quiet);
            end
        end
        i_valid <= 1'b0;

        // Drain the owed samples, then allow for the pipeline latency.
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d points in %0d polylines (%0d lone points); %0d samples compared.",
                 points_sent, polylines, lone_points, checked);
        $display("Receiver stalls included one hold-off of %0d cycles with the input backed up.",
                 LONG_HOLD);
        if (pending != 0) begin
            $display("%0d expected samples never arrived", pending);
        end
        if (mismatches == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/crpi_pkg.sv
hw/rtl/crpi_seq.sv
hw/rtl/crpi_blend.sv
hw/rtl/crpi_scale.sv
hw/rtl/catmull_rom_point_interpolator.sv
bench/crpi_sample_checker.sv
bench/tb_catmull_rom_point_interpolator.sv
